/* rtl/hfas_pkg.sv */
package hfas_pkg;

    localparam logic [15:0] EXP_MASK   = 16'h7C00;
    localparam logic [15:0] HIDDEN_ONE = 16'h0400;
    localparam logic [15:0] SIG_MASK   = 16'h07FF;
    localparam logic [15:0] SIGN_BIT   = 16'h8000;
    localparam logic        LOW_BIT    = 1'b1;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    typedef struct packed {
        logic [15:0] sum_value;
        logic        exponent_out_of_range;
    } hfas_result_t;

endpackage

/* rtl/half_float_add_sub.sv */
// half-precision add/subtract, truncating, no denormals/inf/nan
// input beat: opcode (0 add, 1 subtract), x_operand, y_operand on in_valid/in_ready
// output beat: sum_value and exponent_out_of_range on out_valid/out_ready
// operands are captured in an input register; the arithmetic sits between
// that register and the result register, one operand pair per cycle while out_ready stays high
// out_valid rises when an accepted beat moves from the input register into the result register
// throughput: one beat per cycle when out_ready stays high
// in_ready is high whenever the input stage is empty or can move forward,
// so the block takes one more beat while a finished result waits
// when the receiver stalls the result holds and the pipe fills, then
// in_ready drops; no beat is lost or repeated
// reset clears both valid flags; no results are pending after reset
module half_float_add_sub (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] x_operand,
    input  logic [15:0] y_operand,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] sum_value,
    output logic        exponent_out_of_range
);

    logic        s1_valid_reg;
    logic        op_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic        out_valid_reg;
    hfas_pkg::hfas_result_t res_reg;
    hfas_pkg::hfas_result_t res_next;
    logic        s2_ready;

    // result stage can load when empty or draining
    assign s2_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_ready;

    hfas_core u_core (
        .opcode    (op_reg),
        .x_operand (x_reg),
        .y_operand (y_reg),
        .result    (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready) s1_valid_reg <= in_valid;
            if (s2_ready) out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg <= opcode;
            x_reg  <= x_operand;
            y_reg  <= y_operand;
        end
        if (s2_ready && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign sum_value             = res_reg.sum_value;
    assign exponent_out_of_range = res_reg.exponent_out_of_range;

    // a stalled result holds
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_value))
        else $error("result changed under stall");

    // input stage never drops a beat while blocked
    ap_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg)
        else $error("input stage lost a beat");

    // a zero sum is never flagged
    ap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sum_value == 16'd0 |-> !exponent_out_of_range)
        else $error("zero result flagged");

endmodule

/* rtl/hfas_core.sv */
module hfas_core (
    input  logic                 opcode,
    input  logic [15:0]          x_operand,
    input  logic [15:0]          y_operand,
    output hfas_pkg::hfas_result_t result
);

    logic [15:0] y_eff;
    logic [4:0]  ex;
    logic [4:0]  ey;
    logic [12:0] vx;
    logic [12:0] vy;
    logic [12:0] vx_al;
    logic [12:0] vy_al;
    logic [4:0]  dxy;
    logic [4:0]  dyx;
    logic        x_big;
    logic [4:0]  er;
    logic [12:0] sum;
    logic        neg;
    logic [12:0] mag;
    logic [3:0]  p;
    logic [12:0] norm;
    logic signed [7:0] er_n;
    logic [15:0] packed_res;
    logic        flag;

    always_comb
    begin
        y_eff = y_operand;
        if (opcode == hfas_pkg::OP_SUB && y_operand != 16'd0)
        begin
            y_eff = y_operand ^ hfas_pkg::SIGN_BIT;
        end
        ex = x_operand[14:10];
        ey = y_eff[14:10];
        // 11-bit significand with the implicit one
        vx = {2'b00, x_operand[10:0] | 11'h400};
        vy = {2'b00, y_eff[10:0] | 11'h400};
        if (x_operand[15]) vx = -vx;
        if (y_eff[15]) vy = -vy;
        x_big = ex > ey;
        dxy = ex - ey;
        dyx = ey - ex;
        vx_al = vx;
        vy_al = vy;
        // arithmetic shift past 12 saturates to sign fill
        if (x_big)
        begin
            vy_al = $signed(vy) >>> dxy;
            er = ex;
        end
        else
        begin
            vx_al = $signed(vx) >>> dyx;
            er = ey;
        end
        sum = vx_al + vy_al;
        neg = sum[12];
        mag = neg ? -sum : sum;
        // leading-one search over 12 magnitude bits
        p = 4'd0;
        for (int i = 0; i < 12; i++)
        begin
            if (mag[i]) p = 4'(i);
        end
        norm = mag;
        er_n = 8'($signed({3'b000, er})) + 8'($signed({4'b0000, p})) - 8'sd10;
        if (p < 4'd10) norm = mag << (4'd10 - p);
        else if (p > 4'd10) norm = mag >> (p - 4'd10);
        flag = (er_n < 0) || (er_n > 8'sd31);
        packed_res = {neg, er_n[4:0], norm[9:0]};
        if (x_operand == 16'd0 || y_eff == 16'd0)
        begin
            result.sum_value = (x_operand != 16'd0) ? x_operand : y_eff;
            result.exponent_out_of_range = 1'b0;
        end
        else if (sum == 13'd0)
        begin
            result.sum_value = 16'd0;
            result.exponent_out_of_range = 1'b0;
        end
        else
        begin
            result.sum_value = packed_res;
            result.exponent_out_of_range = flag & hfas_pkg::LOW_BIT;
        end
    end

endmodule
